[rtl/core/psd_pkg.sv]
// package for the polyline signed distance block: constants and types
package psd_pkg;

    localparam int MaxPoints = 256;
    localparam int IdxW      = $clog2(MaxPoints);
    localparam int CntW      = IdxW + 1;

    localparam logic [1:0] OpClear  = 2'd0;
    localparam logic [1:0] OpAppend = 2'd1;
    localparam logic [1:0] OpQuery  = 2'd2;

    localparam logic [30:0] HalfWidthReset = 31'd32768;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RD0,
        ST_RD1,
        ST_DIFF,
        ST_M_DS,
        ST_M_LS,
        ST_M_CR,
        ST_CLS,
        ST_DIV,
        ST_OFFX,
        ST_OFFY,
        ST_E,
        ST_D2,
        ST_CMP,
        ST_NEXT,
        ST_SQRT,
        ST_OUT
    } psd_state_t;

    // request to the shared multiplier: 34 x 34 signed
    typedef struct packed {
        logic               go;
        logic signed [33:0] a;
        logic signed [33:0] b;
    } psd_mul_req_t;

endpackage

[rtl/core/polyline_signed_distance.sv]
// top level of the polyline signed distance block
// An item carries an op: clear, append a vertex, or query a point. Clear and append
// complete without leaving the idle state. A query with n >= 2 stored vertices walks
// the n-1 segments one after another through a single shared 34x34 multiplier and a
// one-bit-per-cycle restoring divider for the projection parameter, then takes a
// 32-step bit-pair square root of the best squared distance. A segment takes ten
// serial multiplications, plus the 32-step divide when t is not clamped; a query
// with fewer than two vertices goes straight to the output state. The vertex store
// is a 1r1w memory read one address per cycle. in_stall is high while a query is
// in work. A finished result sits in an output register, so further items are
// taken while it waits; a query that finishes before the waiting result has gone
// holds in its last state.
module polyline_signed_distance (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         op,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] distance,
    output logic               on_line,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [30:0]        cfg_data
);
    import psd_pkg::*;

    // vertex store, no reset
    logic [31:0] mem_x [MaxPoints];
    logic [31:0] mem_y [MaxPoints];
    logic signed [31:0] rd_x, rd_y;
    logic [IdxW-1:0] rd_addr;

    psd_state_t state_reg, state_next;
    logic [CntW-1:0] count_reg, count_next;
    logic [CntW-1:0] seg_reg, seg_next;
    logic [30:0] hw_reg;
    logic [2:0]  mstep_reg, mstep_next;
    logic [5:0]  it_reg, it_next;
    logic        out_valid_reg, out_valid_next;

    // query point and segment data
    logic signed [31:0] px_reg, py_reg;
    logic signed [31:0] x0_reg, y0_reg;
    logic signed [32:0] sx_reg, sy_reg, dx_reg, dy_reg;
    logic signed [67:0] acc_reg, acc_next;
    logic signed [67:0] dot_reg, len_reg, cr_reg;
    logic [67:0] rem_reg;
    logic [32:0] t_reg;
    logic signed [33:0] ex_reg, ey_reg;
    logic [67:0] best_reg;
    logic        best_neg_reg, first_reg;
    logic [63:0] sq_v_reg;
    logic [31:0] sq_rem_reg;
    logic [31:0] sq_res_reg;
    logic [31:0] sd_reg;
    logic        ol_reg;

    psd_mul_req_t mreq;
    logic signed [67:0] mprod;
    logic mdone;

    psd_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .prod  (mprod),
        .done  (mdone)
    );

    logic accept;
    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign distance  = sd_reg;
    assign on_line   = ol_reg;

    always_ff @(posedge clk)
    begin
        if (accept && op == OpAppend && count_reg < CntW'(MaxPoints))
        begin
            mem_x[count_reg[IdxW-1:0]] <= point_x;
            mem_y[count_reg[IdxW-1:0]] <= point_y;
        end
        rd_x <= mem_x[rd_addr];
        rd_y <= mem_y[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            seg_reg       <= '0;
            hw_reg        <= HalfWidthReset;
            mstep_reg     <= '0;
            it_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            seg_reg       <= seg_next;
            mstep_reg     <= mstep_next;
            it_reg        <= it_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                hw_reg <= cfg_data;
        end
    end

    // the sqrt bit pair step: partial remainder with the next two bits appended
    logic [33:0] sq_trial;
    logic [33:0] sq_rem_top;
    assign sq_trial   = {sq_res_reg, 2'b01};
    assign sq_rem_top = {sq_rem_reg, sq_v_reg[63:62]};

    logic [68:0] div_shift;
    assign div_shift = {rem_reg, 1'b0};

    logic [32:0] mag_sx, mag_sy;
    assign mag_sx = sx_reg[32] ? 33'(-sx_reg) : 33'(sx_reg);
    assign mag_sy = sy_reg[32] ? 33'(-sy_reg) : 33'(sy_reg);

    // datapath registers
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (accept)
        begin
            px_reg <= point_x;
            py_reg <= point_y;
        end
        case (state_reg)
            ST_RD0:
            begin
                first_reg <= 1'b1;
            end
            ST_RD1:
            begin
                x0_reg <= rd_x;
                y0_reg <= rd_y;
            end
            ST_DIFF:
            begin
                sx_reg <= 33'(rd_x) - 33'(x0_reg);
                sy_reg <= 33'(rd_y) - 33'(y0_reg);
                dx_reg <= 33'(px_reg) - 33'(x0_reg);
                dy_reg <= 33'(py_reg) - 33'(y0_reg);
                x0_reg <= rd_x;
                y0_reg <= rd_y;
            end
            ST_M_DS: if (mstep_reg == 3'd3 && mdone) dot_reg <= acc_next;
            ST_M_LS: if (mstep_reg == 3'd3 && mdone) len_reg <= acc_next;
            ST_M_CR: if (mstep_reg == 3'd3 && mdone) cr_reg <= acc_next;
            ST_CLS:
            begin
                rem_reg <= dot_reg;
                if (len_reg != 0 && dot_reg > 0 && dot_reg >= len_reg)
                    t_reg <= 33'h1_0000_0000;
                else
                    t_reg <= '0;
            end
            ST_DIV:
            begin
                if (div_shift >= 69'(len_reg))
                begin
                    rem_reg <= 68'(div_shift - 69'(len_reg));
                    t_reg   <= {t_reg[31:0], 1'b1};
                end
                else
                begin
                    rem_reg <= 68'(div_shift);
                    t_reg   <= {t_reg[31:0], 1'b0};
                end
            end
            ST_OFFX: if (mdone)
                ex_reg <= 34'(dx_reg) - (sx_reg[32] ? -34'(mprod[63:32]) : 34'(mprod[63:32]));
            ST_OFFY: if (mdone)
                ey_reg <= 34'(dy_reg) - (sy_reg[32] ? -34'(mprod[63:32]) : 34'(mprod[63:32]));
            ST_CMP:
            begin
                first_reg <= 1'b0;
                if (first_reg || acc_reg < $signed(best_reg))
                begin
                    best_reg     <= acc_reg;
                    best_neg_reg <= cr_reg[67];
                end
            end
            ST_NEXT:
            begin
                sq_res_reg <= '0;
                sq_rem_reg <= '0;
                if (best_reg[67:64] != 0)
                    sq_v_reg <= '0;
                else
                    sq_v_reg <= best_reg[63:0];
            end
            ST_SQRT:
            begin
                sq_v_reg <= sq_v_reg << 2;
                if (sq_rem_top >= sq_trial)
                begin
                    sq_rem_reg <= 32'(sq_rem_top - sq_trial);
                    sq_res_reg <= {sq_res_reg[30:0], 1'b1};
                end
                else
                begin
                    sq_rem_reg <= sq_rem_top[31:0];
                    sq_res_reg <= {sq_res_reg[30:0], 1'b0};
                end
            end
            ST_OUT:
            begin
                // only load once the previous result has gone
                if (!out_valid_reg || !out_stall)
                begin
                    // magnitude saturation and sign
                    if (count_reg < CntW'(2))
                    begin
                        sd_reg <= '0;
                        ol_reg <= (hw_reg != 0);
                    end
                    else if (best_reg[67:64] != 0)
                    begin
                        sd_reg <= best_neg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
                        ol_reg <= 1'b0;
                    end
                    else if (best_neg_reg)
                    begin
                        sd_reg <= (sq_res_reg > 32'h8000_0000) ? 32'h8000_0000 : -sq_res_reg;
                        ol_reg <= ({1'b0, sq_res_reg} < {2'b00, hw_reg});
                    end
                    else
                    begin
                        sd_reg <= sq_res_reg[31] ? 32'h7FFF_FFFF : sq_res_reg;
                        ol_reg <= ({1'b0, sq_res_reg[31] ? 32'h7FFF_FFFF : sq_res_reg}
                                   < {2'b00, hw_reg});
                    end
                end
            end
            default: ;
        endcase
    end

    // sequencer; products of a sum of two are issued in mstep 0 and 1 and summed
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        seg_next       = seg_reg;
        mstep_next     = mstep_reg;
        it_next        = it_reg;
        out_valid_next = out_valid_reg && out_stall;
        acc_next       = acc_reg;
        rd_addr        = seg_reg[IdxW-1:0];
        mreq.go        = 1'b0;
        mreq.a         = '0;
        mreq.b         = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        OpClear:  count_next = '0;
                        OpAppend: if (count_reg < CntW'(MaxPoints))
                                      count_next = count_reg + 1'b1;
                        OpQuery:
                        begin
                            seg_next   = '0;
                            state_next = (count_reg < CntW'(2)) ? ST_OUT : ST_RD0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RD0:
            begin
                rd_addr    = '0;
                seg_next   = CntW'(1);
                state_next = ST_RD1;
            end
            ST_RD1:
            begin
                rd_addr    = seg_reg[IdxW-1:0];
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                mstep_next = '0;
                state_next = ST_M_DS;
            end
            ST_M_DS, ST_M_LS, ST_M_CR, ST_D2:
            begin
                if (mstep_reg < 3'd2)
                begin
                    mreq.go    = 1'b1;
                    mstep_next = mstep_reg + 1'b1;
                    case (state_reg)
                        ST_M_DS:
                        begin
                            mreq.a = mstep_reg[0] ? 34'(dy_reg) : 34'(dx_reg);
                            mreq.b = mstep_reg[0] ? 34'(sy_reg) : 34'(sx_reg);
                        end
                        ST_M_LS:
                        begin
                            mreq.a = mstep_reg[0] ? 34'(sy_reg) : 34'(sx_reg);
                            mreq.b = mstep_reg[0] ? 34'(sy_reg) : 34'(sx_reg);
                        end
                        ST_M_CR:
                        begin
                            mreq.a = mstep_reg[0] ? -34'(sy_reg) : 34'(sx_reg);
                            mreq.b = mstep_reg[0] ? 34'(dx_reg) : 34'(dy_reg);
                        end
                        default:
                        begin
                            mreq.a = mstep_reg[0] ? ey_reg : ex_reg;
                            mreq.b = mstep_reg[0] ? ey_reg : ex_reg;
                        end
                    endcase
                end
                else if (mstep_reg == 3'd2)
                begin
                    if (mdone)
                    begin
                        acc_next   = mprod;
                        mstep_next = 3'd3;
                    end
                end
                else if (mdone)
                begin
                    acc_next   = acc_reg + mprod;
                    mstep_next = '0;
                    case (state_reg)
                        ST_M_DS: state_next = ST_M_LS;
                        ST_M_LS: state_next = ST_M_CR;
                        ST_M_CR: state_next = ST_CLS;
                        default: state_next = ST_CMP;
                    endcase
                end
            end
            ST_CLS:
            begin
                it_next = '0;
                if (len_reg == 0 || dot_reg <= 0 || dot_reg >= len_reg)
                    state_next = ST_OFFX;
                else
                    state_next = ST_DIV;
                mstep_next = '0;
            end
            ST_DIV:
            begin
                it_next = it_reg + 1'b1;
                if (it_reg == 6'd31)
                    state_next = ST_OFFX;
            end
            ST_OFFX, ST_OFFY:
            begin
                if (mstep_reg == 3'd0)
                begin
                    mreq.go    = 1'b1;
                    mreq.a     = $signed({1'b0, (state_reg == ST_OFFX) ? mag_sx : mag_sy});
                    mreq.b     = $signed({1'b0, t_reg});
                    mstep_next = 3'd1;
                end
                else if (mdone)
                begin
                    mstep_next = '0;
                    state_next = (state_reg == ST_OFFX) ? ST_OFFY : ST_D2;
                end
            end
            ST_CMP:
            begin
                state_next = ST_NEXT;
            end
            ST_NEXT:
            begin
                if (seg_reg + 1'b1 < count_reg)
                begin
                    seg_next   = seg_reg + 1'b1;
                    state_next = ST_RD1;
                end
                else
                begin
                    it_next    = '0;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                it_next = it_reg + 1'b1;
                if (it_reg == 6'd31)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

[rtl/core/psd_mul.sv]
// shared signed multiplier, split into four 17x17 partial products over stages
module psd_mul (
    input  logic                  clk,
    input  logic                  rst_n,
    input  psd_pkg::psd_mul_req_t req,
    output logic signed [67:0]    prod,
    output logic                  done
);
    import psd_pkg::*;

    logic [33:0] ma_reg, mb_reg;
    logic        neg_reg, neg2_reg;
    logic        v1_reg, v2_reg;
    logic [33:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic [67:0] sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            done   <= 1'b0;
        end
        else
        begin
            v1_reg <= req.go;
            v2_reg <= v1_reg;
            done   <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ma_reg   <= req.a[33] ? 34'(-req.a) : 34'(req.a);
        mb_reg   <= req.b[33] ? 34'(-req.b) : 34'(req.b);
        neg_reg  <= req.a[33] ^ req.b[33];
        p00_reg  <= {17'd0, ma_reg[16:0]} * {17'd0, mb_reg[16:0]};
        p01_reg  <= {17'd0, ma_reg[16:0]} * {17'd0, mb_reg[33:17]};
        p10_reg  <= {17'd0, ma_reg[33:17]} * {17'd0, mb_reg[16:0]};
        p11_reg  <= {17'd0, ma_reg[33:17]} * {17'd0, mb_reg[33:17]};
        neg2_reg <= neg_reg;
        prod     <= neg2_reg ? -$signed(sum) : $signed(sum);
    end

    assign sum = {p11_reg, 34'd0} + ({34'd0, p01_reg} << 17)
               + ({34'd0, p10_reg} << 17) + {34'd0, p00_reg};

endmodule

[rtl/core/psd_checker.sv]
// port-level checker for the polyline signed distance block, bound to the top level
module psd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [1:0]  op,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] distance,
    input logic        on_line
);
    import psd_pkg::*;

    // a waiting result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(distance))
        else $error("result dropped under stall");

    // the on-line flag of a waiting result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(on_line))
        else $error("on_line changed under stall");

    // with no result waiting, a non-query item never raises a result on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && op != OpQuery && !out_valid |=> !out_valid)
        else $error("result from non-query item");

    // a query blocks input the cycle after
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && op == OpQuery |=> in_stall)
        else $error("query not held");

endmodule

bind polyline_signed_distance psd_checker u_psd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .distance  (distance),
    .on_line   (on_line)
);
